// ----- rtl/dwsl_pkg.sv -----
`timescale 1ns / 1ps

package dwsl_pkg;

  // Encoder count width.
  localparam int COUNT_WIDTH = 16;

  // Division by 100 is done as a multiply by a reciprocal and a right shift.
  // The reciprocal is folded into the scale register when it is written.
  localparam int SCALE_W     = 10;
  localparam int SPEED_W     = 8;
  localparam int RECIP_SHIFT = 25;
  localparam int RECIP_K     = 335545;
  localparam int SCALE_K_W   = 29;
  localparam int PROD_W      = SPEED_W + SCALE_K_W;
  localparam int MAG_W       = PROD_W - RECIP_SHIFT;
  localparam int TGT_W       = MAG_W + 1;

  // Controller datapath widths.
  localparam int ERR_W   = ((COUNT_WIDTH > TGT_W) ? COUNT_WIDTH : TGT_W) + 1;
  localparam int DERR_W  = ERR_W + 1;
  localparam int PE_W    = ERR_W + 9;
  localparam int ACCS_W  = PE_W + 1;
  localparam int DPROD_W = DERR_W + 17;
  localparam int NUM_W   = ACCS_W + 16 + 1;
  localparam int QUO_W   = NUM_W - 16;
  localparam int DRIVE_W = 16;

  // Configuration port.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [7:0]           PROP_GAIN_RST = 8'd7;
  localparam logic [15:0]          DIFF_GAIN_RST = 16'd197;
  localparam logic [14:0]          LIMIT_RST     = 15'd7199;
  localparam logic [7:0]           TIMEOUT_RST   = 8'd15;
  localparam logic [7:0]           MARGIN_RST    = 8'd30;
  localparam logic [SCALE_W-1:0]   SCALE_RST     = 10'd280;
  localparam logic [SCALE_K_W-1:0] SCALE_K_RST   = SCALE_K_W'(280 * RECIP_K);

  localparam logic [7:0] DIR_FORWARD = 8'd0;
  localparam logic [7:0] DIR_REVERSE = 8'd1;

  typedef enum logic [2:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_DIFF_GAIN    = 3'd1,
    REG_DRIVE_LIMIT  = 3'd2,
    REG_TIMEOUT      = 3'd3,
    REG_TURN_MARGIN  = 3'd4,
    REG_TARGET_SCALE = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    LIGHT_OFF   = 3'd0,
    LIGHT_ON    = 3'd1,
    LIGHT_LEFT  = 3'd2,
    LIGHT_RIGHT = 3'd3,
    LIGHT_REAR  = 3'd4,
    LIGHT_NONE  = 3'd5
  } light_e;

  typedef struct packed {
    logic [7:0]           prop_gain;
    logic [15:0]          diff_gain;
    logic [14:0]          drive_limit;
    logic [7:0]           timeout_ticks;
    logic [7:0]           turn_margin;
    logic [SCALE_K_W-1:0] scale_k;
  } cfg_t;

endpackage

// ----- rtl/dwsl_cfg.sv -----
`timescale 1ns / 1ps

module dwsl_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dwsl_pkg::ADDR_W-1:0] paddr,
  input  logic [dwsl_pkg::DATA_W-1:0] pwdata,
  output logic [dwsl_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output dwsl_pkg::cfg_t              cfg_o
);
  import dwsl_pkg::*;

  logic [7:0]           prop_gain_q;
  logic [15:0]          diff_gain_q;
  logic [14:0]          limit_q;
  logic [7:0]           timeout_q;
  logic [7:0]           margin_q;
  logic [SCALE_W-1:0]   scale_q;
  logic [SCALE_K_W-1:0] scale_k_q;
  logic [SCALE_K_W-1:0] scale_k_d;
  logic                 wr_en;
  reg_idx_e             idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[4:2]);

  // The scale is stored premultiplied by the reciprocal of 100.
  assign scale_k_d = SCALE_K_W'(pwdata[SCALE_W-1:0] * SCALE_K_W'(RECIP_K));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q <= PROP_GAIN_RST;
      diff_gain_q <= DIFF_GAIN_RST;
      limit_q     <= LIMIT_RST;
      timeout_q   <= TIMEOUT_RST;
      margin_q    <= MARGIN_RST;
      scale_q     <= SCALE_RST;
      scale_k_q   <= SCALE_K_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_PROP_GAIN:    prop_gain_q <= pwdata[7:0];
        REG_DIFF_GAIN:    diff_gain_q <= pwdata[15:0];
        REG_DRIVE_LIMIT:  limit_q     <= pwdata[14:0];
        REG_TIMEOUT:      timeout_q   <= pwdata[7:0];
        REG_TURN_MARGIN:  margin_q    <= pwdata[7:0];
        REG_TARGET_SCALE: begin
          scale_q   <= pwdata[SCALE_W-1:0];
          scale_k_q <= scale_k_d;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PROP_GAIN:    prdata = DATA_W'(prop_gain_q);
      REG_DIFF_GAIN:    prdata = DATA_W'(diff_gain_q);
      REG_DRIVE_LIMIT:  prdata = DATA_W'(limit_q);
      REG_TIMEOUT:      prdata = DATA_W'(timeout_q);
      REG_TURN_MARGIN:  prdata = DATA_W'(margin_q);
      REG_TARGET_SCALE: prdata = DATA_W'(scale_q);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o.prop_gain     = prop_gain_q;
  assign cfg_o.diff_gain     = diff_gain_q;
  assign cfg_o.drive_limit   = limit_q;
  assign cfg_o.timeout_ticks = timeout_q;
  assign cfg_o.turn_margin   = margin_q;
  assign cfg_o.scale_k       = scale_k_q;

endmodule

// ----- rtl/dwsl_cmd_decode.sv -----
`timescale 1ns / 1ps

module dwsl_cmd_decode (
  input  dwsl_pkg::cfg_t                    cfg_i,
  input  logic [7:0]                        left_dir_i,
  input  logic [7:0]                        left_speed_i,
  input  logic [7:0]                        right_dir_i,
  input  logic [7:0]                        right_speed_i,
  output logic signed [dwsl_pkg::TGT_W-1:0] left_tgt_o,
  output logic signed [dwsl_pkg::TGT_W-1:0] right_tgt_o,
  output dwsl_pkg::light_e                  light_o
);
  import dwsl_pkg::*;

  logic [PROD_W-1:0]        l_prod;
  logic [PROD_W-1:0]        r_prod;
  logic signed [TGT_W-1:0]  l_pos;
  logic signed [TGT_W-1:0]  r_pos;

  // floor(speed * scale / 100) via the premultiplied reciprocal.
  assign l_prod = PROD_W'(left_speed_i) * PROD_W'(cfg_i.scale_k);
  assign r_prod = PROD_W'(right_speed_i) * PROD_W'(cfg_i.scale_k);
  assign l_pos  = {1'b0, l_prod[PROD_W-1:RECIP_SHIFT]};
  assign r_pos  = {1'b0, r_prod[PROD_W-1:RECIP_SHIFT]};

  assign left_tgt_o  = (left_dir_i == DIR_REVERSE) ? -l_pos : l_pos;
  assign right_tgt_o = (right_dir_i == DIR_REVERSE) ? -r_pos : r_pos;

  always_comb begin
    if (left_speed_i == 8'd0 && right_speed_i == 8'd0) begin
      light_o = LIGHT_OFF;
    end else if (left_dir_i == DIR_REVERSE && right_dir_i == DIR_REVERSE) begin
      light_o = LIGHT_REAR;
    end else if (left_dir_i == DIR_FORWARD && right_dir_i == DIR_FORWARD) begin
      if (right_speed_i >= left_speed_i &&
          (right_speed_i - left_speed_i) >= cfg_i.turn_margin) begin
        light_o = LIGHT_LEFT;
      end else if (left_speed_i >= right_speed_i &&
                   (left_speed_i - right_speed_i) >= cfg_i.turn_margin) begin
        light_o = LIGHT_RIGHT;
      end else begin
        light_o = LIGHT_ON;
      end
    end else begin
      light_o = LIGHT_OFF;
    end
  end

endmodule

// ----- rtl/dwsl_wheel.sv -----
`timescale 1ns / 1ps

module dwsl_wheel (
  input  dwsl_pkg::cfg_t                          cfg_i,
  input  logic signed [dwsl_pkg::TGT_W-1:0]       tgt_i,
  input  logic signed [dwsl_pkg::COUNT_WIDTH-1:0] count_i,
  input  logic signed [dwsl_pkg::DRIVE_W-1:0]     acc_i,
  input  logic signed [dwsl_pkg::ERR_W-1:0]       prev_i,
  output logic signed [dwsl_pkg::DRIVE_W-1:0]     drive_o,
  output logic signed [dwsl_pkg::ERR_W-1:0]       err_o
);
  import dwsl_pkg::*;

  logic signed [ERR_W-1:0]   err;
  logic signed [DERR_W-1:0]  derr;
  logic signed [8:0]         kp;
  logic signed [16:0]        kd;
  logic signed [PE_W-1:0]    p_term;
  logic signed [DPROD_W-1:0] d_term;
  logic signed [ACCS_W-1:0]  acc_sum;
  logic signed [NUM_W-1:0]   num;
  logic signed [QUO_W-1:0]   quo;
  logic signed [QUO_W-1:0]   quo_trunc;
  logic signed [QUO_W-1:0]   lim;
  logic signed [DRIVE_W-1:0] clamped;
  logic                      tgt_zero;

  assign tgt_zero = (tgt_i == '0);

  assign err  = {{(ERR_W-TGT_W){tgt_i[TGT_W-1]}}, tgt_i}
              - {{(ERR_W-COUNT_WIDTH){count_i[COUNT_WIDTH-1]}}, count_i};
  assign derr = {err[ERR_W-1], err} - {prev_i[ERR_W-1], prev_i};

  assign kp = {1'b0, cfg_i.prop_gain};
  assign kd = {1'b0, cfg_i.diff_gain};

  assign p_term  = kp * err;
  assign d_term  = kd * derr;
  assign acc_sum = {{(ACCS_W-DRIVE_W){acc_i[DRIVE_W-1]}}, acc_i}
                 + {p_term[PE_W-1], p_term};

  // Sum in Q.16, then divide by 65536 rounding toward zero.
  assign num = {acc_sum[ACCS_W-1], acc_sum, 16'h0000}
             + {{(NUM_W-DPROD_W){d_term[DPROD_W-1]}}, d_term};
  assign quo = num[NUM_W-1:16];
  assign quo_trunc = quo + QUO_W'(num[NUM_W-1] && (num[15:0] != 16'h0000));

  assign lim = {{(QUO_W-15){1'b0}}, cfg_i.drive_limit};

  always_comb begin
    if (quo_trunc > lim) begin
      clamped = lim[DRIVE_W-1:0];
    end else if (quo_trunc < -lim) begin
      clamped = DRIVE_W'(-lim);
    end else begin
      clamped = quo_trunc[DRIVE_W-1:0];
    end
  end

  // A zero target parks the wheel: no drive and a cleared error history.
  assign drive_o = tgt_zero ? '0 : clamped;
  assign err_o   = tgt_zero ? '0 : err;

endmodule

// ----- rtl/dual_wheel_speed_loop.sv -----
`timescale 1ns / 1ps

// A request passes through the input register and the target register into the result
// register before it shows on the outputs.
// Throughput: one request per cycle while not stalled; the controller state is updated with each request.
// A stalled output freezes the whole pipeline and raises in_stall_o.
// Reset clears the pipeline and loads the register defaults; targets, accumulators and
// errors start at zero, the idle count at the timeout, and no light code counts as shown.
module dual_wheel_speed_loop (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [dwsl_pkg::ADDR_W-1:0]             paddr,
  input  logic [dwsl_pkg::DATA_W-1:0]             pwdata,
  output logic [dwsl_pkg::DATA_W-1:0]             prdata,
  output logic                                    pready,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    cmd_valid_i,
  input  logic [7:0]                              left_dir_i,
  input  logic [7:0]                              left_speed_i,
  input  logic [7:0]                              right_dir_i,
  input  logic [7:0]                              right_speed_i,
  input  logic signed [dwsl_pkg::COUNT_WIDTH-1:0] left_count_i,
  input  logic signed [dwsl_pkg::COUNT_WIDTH-1:0] right_count_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [15:0]                      left_drive_o,
  output logic signed [15:0]                      right_drive_o,
  output logic                                    light_update_o,
  output logic [2:0]                              light_code_o
);
  import dwsl_pkg::*;

  cfg_t cfg;
  logic en;

  // Stage 1: raw request.
  logic                          s1_valid_q;
  logic                          s1_cmd_q;
  logic [7:0]                    s1_ldir_q, s1_lsp_q, s1_rdir_q, s1_rsp_q;
  logic signed [COUNT_WIDTH-1:0] s1_lcnt_q, s1_rcnt_q;

  // Stage 2: decoded command.
  logic                          s2_valid_q;
  logic                          s2_cmd_q;
  logic signed [TGT_W-1:0]       s2_ltgt_q, s2_rtgt_q;
  light_e                        s2_light_q;
  logic signed [COUNT_WIDTH-1:0] s2_lcnt_q, s2_rcnt_q;

  logic signed [TGT_W-1:0]       dec_ltgt, dec_rtgt;
  light_e                        dec_light;

  // Loop state.
  logic signed [TGT_W-1:0]   l_tgt_q, r_tgt_q, l_tgt_d, r_tgt_d;
  logic signed [DRIVE_W-1:0] l_acc_q, r_acc_q, l_drive, r_drive;
  logic signed [ERR_W-1:0]   l_prev_q, r_prev_q, l_err, r_err;
  logic [7:0]                idle_q, idle_d;
  light_e                    last_light_q, light_d;
  logic                      stop;

  // Result register.
  logic                      out_valid_q;
  logic signed [DRIVE_W-1:0] out_ldrive_q, out_rdrive_q;
  logic                      out_upd_q;
  light_e                    out_code_q;

  dwsl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      s1_cmd_q  <= cmd_valid_i;
      s1_ldir_q <= left_dir_i;
      s1_lsp_q  <= left_speed_i;
      s1_rdir_q <= right_dir_i;
      s1_rsp_q  <= right_speed_i;
      s1_lcnt_q <= left_count_i;
      s1_rcnt_q <= right_count_i;
    end
  end

  dwsl_cmd_decode u_decode (
    .cfg_i         (cfg),
    .left_dir_i    (s1_ldir_q),
    .left_speed_i  (s1_lsp_q),
    .right_dir_i   (s1_rdir_q),
    .right_speed_i (s1_rsp_q),
    .left_tgt_o    (dec_ltgt),
    .right_tgt_o   (dec_rtgt),
    .light_o       (dec_light)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s1_valid_q) begin
      s2_cmd_q   <= s1_cmd_q;
      s2_ltgt_q  <= dec_ltgt;
      s2_rtgt_q  <= dec_rtgt;
      s2_light_q <= dec_light;
      s2_lcnt_q  <= s1_lcnt_q;
      s2_rcnt_q  <= s1_rcnt_q;
    end
  end

  // Command timeout and target selection. The timeout check also applies on
  // a tick that carries a command, so a zero timeout stops the wheels at once.
  always_comb begin
    if (s2_cmd_q) begin
      idle_d = '0;
    end else if (idle_q < cfg.timeout_ticks) begin
      idle_d = idle_q + 8'd1;
    end else begin
      idle_d = idle_q;
    end
    stop = (idle_d >= cfg.timeout_ticks);

    if (stop) begin
      l_tgt_d = '0;
      r_tgt_d = '0;
      light_d = LIGHT_OFF;
    end else if (s2_cmd_q) begin
      l_tgt_d = s2_ltgt_q;
      r_tgt_d = s2_rtgt_q;
      light_d = s2_light_q;
    end else begin
      l_tgt_d = l_tgt_q;
      r_tgt_d = r_tgt_q;
      light_d = last_light_q;
    end
  end

  dwsl_wheel u_left (
    .cfg_i   (cfg),
    .tgt_i   (l_tgt_d),
    .count_i (s2_lcnt_q),
    .acc_i   (l_acc_q),
    .prev_i  (l_prev_q),
    .drive_o (l_drive),
    .err_o   (l_err)
  );

  dwsl_wheel u_right (
    .cfg_i   (cfg),
    .tgt_i   (r_tgt_d),
    .count_i (s2_rcnt_q),
    .acc_i   (r_acc_q),
    .prev_i  (r_prev_q),
    .drive_o (r_drive),
    .err_o   (r_err)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_tgt_q      <= '0;
      r_tgt_q      <= '0;
      l_acc_q      <= '0;
      r_acc_q      <= '0;
      l_prev_q     <= '0;
      r_prev_q     <= '0;
      idle_q       <= TIMEOUT_RST;
      last_light_q <= LIGHT_NONE;
      out_valid_q  <= 1'b0;
    end else if (en) begin
      out_valid_q <= s2_valid_q;
      if (s2_valid_q) begin
        l_tgt_q      <= l_tgt_d;
        r_tgt_q      <= r_tgt_d;
        l_acc_q      <= l_drive;
        r_acc_q      <= r_drive;
        l_prev_q     <= l_err;
        r_prev_q     <= r_err;
        idle_q       <= idle_d;
        last_light_q <= light_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s2_valid_q) begin
      out_ldrive_q <= l_drive;
      out_rdrive_q <= r_drive;
      out_upd_q    <= (light_d != last_light_q);
      out_code_q   <= (light_d != last_light_q) ? light_d : LIGHT_OFF;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_drive_o   = out_ldrive_q;
  assign right_drive_o  = out_rdrive_q;
  assign light_update_o = out_upd_q;
  assign light_code_o   = out_code_q;

  a_stall_only_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the result register is free");

  a_code_zero_without_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !light_update_o) |-> (light_code_o == LIGHT_OFF))
    else $error("light code shown without an update");

  a_update_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && light_update_o) |-> (light_code_o == last_light_q))
    else $error("reported light code differs from the stored code");

  a_left_parked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (l_tgt_q == '0) |-> (l_acc_q == '0 && l_prev_q == '0))
    else $error("left wheel keeps history with a zero target");

  a_right_parked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r_tgt_q == '0) |-> (r_acc_q == '0 && r_prev_q == '0))
    else $error("right wheel keeps history with a zero target");

endmodule
